// ===== rtl/core/rie_pkg.sv =====
// Package: shared types, opcodes and constants for the instruction execute unit.
`default_nettype none
package rie_pkg;

    localparam int unsigned DMEM_WORDS_DEF = 1024;
    localparam logic [31:0] PC_RESET      = 32'h0040_0000;
    localparam logic [31:0] SYSCALL_HALT  = 32'd10;
    localparam logic [4:0]  REG_V0        = 5'd2;
    localparam logic [4:0]  REG_RA        = 5'd31;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;

    localparam logic [4:0] RT_BLTZ    = 5'h00;
    localparam logic [4:0] RT_BGEZ    = 5'h01;
    localparam logic [4:0] RT_BLTZAL  = 5'h10;
    localparam logic [4:0] RT_BGEZAL  = 5'h11;

    typedef struct packed {
        logic [31:0] instr_word;
    } t_instr;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_we;
        logic [4:0]  reg_idx;
        logic [31:0] reg_val;
        logic [31:0] hi_val;
        logic [31:0] lo_val;
        logic        mem_we;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic [3:0]  mem_lanes;
        logic        halted;
    } t_result;

    typedef enum logic [1:0] {
        MD_MULT,
        MD_MULTU,
        MD_DIV,
        MD_DIVU
    } t_md_op;

    typedef struct packed {
        logic        start;
        t_md_op      op;
        logic [31:0] a;
        logic [31:0] b;
    } t_md_req;

    typedef struct packed {
        logic        done;
        logic [31:0] hi;
        logic [31:0] lo;
    } t_md_rsp;

    typedef enum logic [1:0] {
        MDS_IDLE,
        MDS_RUN,
        MDS_FIX
    } t_md_state;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDA,
        ST_RDB,
        ST_EXEC,
        ST_MDWAIT,
        ST_IDXFIX,
        ST_MEMRD,
        ST_MEMWR,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/core/rie_chan_if.sv =====
// Interface: valid/ready channel carrying one payload per transaction.
`default_nettype none
interface rie_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rie_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rie_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/rie_muldiv.sv =====
// Iterative multiply/divide unit: one product or quotient bit per cycle.
`default_nettype none
module rie_muldiv (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  rie_pkg::t_md_req i_req,
    output rie_pkg::t_md_rsp o_rsp
);
    import rie_pkg::*;

    t_md_state   r_state;
    logic [63:0] r_acc;
    logic [31:0] r_mb;
    logic [4:0]  r_cnt;
    logic        r_div;
    logic        r_neg_q;
    logic        r_neg_r;
    logic        r_done;
    logic [31:0] r_hi;
    logic [31:0] r_lo;

    logic        sgn;
    logic        na;
    logic        nb;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [32:0] msum;
    logic [32:0] dtry;
    logic [63:0] pneg;
    logic [31:0] qfix;
    logic [31:0] rfix;

    always_comb begin
        sgn  = (i_req.op == MD_MULT) || (i_req.op == MD_DIV);
        na   = sgn & i_req.a[31];
        nb   = sgn & i_req.b[31];
        ma   = na ? (32'd0 - i_req.a) : i_req.a;
        mb   = nb ? (32'd0 - i_req.b) : i_req.b;
        msum = {1'b0, r_acc[63:32]} + (r_acc[0] ? {1'b0, r_mb} : 33'd0);
        dtry = r_acc[63:31] - {1'b0, r_mb};
        pneg = r_neg_q ? (64'd0 - r_acc) : r_acc;
        qfix = r_neg_q ? (32'd0 - r_acc[31:0]) : r_acc[31:0];
        rfix = r_neg_r ? (32'd0 - r_acc[63:32]) : r_acc[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MDS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                MDS_IDLE: begin
                    if (i_req.start) begin
                        r_state <= MDS_RUN;
                    end
                end
                MDS_RUN: begin
                    if (r_cnt == 5'd31) begin
                        r_state <= MDS_FIX;
                    end
                end
                MDS_FIX: begin
                    r_state <= MDS_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= MDS_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            MDS_IDLE: begin
                r_cnt   <= 5'd0;
                r_div   <= (i_req.op == MD_DIV) || (i_req.op == MD_DIVU);
                r_neg_q <= na ^ nb;
                r_neg_r <= na;
                if ((i_req.op == MD_DIV) || (i_req.op == MD_DIVU)) begin
                    r_acc <= {32'd0, ma};
                    r_mb  <= mb;
                end else begin
                    r_acc <= {32'd0, mb};
                    r_mb  <= ma;
                end
            end
            MDS_RUN: begin
                r_cnt <= r_cnt + 5'd1;
                if (r_div) begin
                    if (!dtry[32]) begin
                        r_acc <= {dtry[31:0], r_acc[30:0], 1'b1};
                    end else begin
                        r_acc <= {r_acc[62:0], 1'b0};
                    end
                end else begin
                    r_acc <= {msum, r_acc[31:1]};
                end
            end
            MDS_FIX: begin
                if (r_div) begin
                    r_hi <= rfix;
                    r_lo <= qfix;
                end else begin
                    r_hi <= pneg[63:32];
                    r_lo <= pneg[31:0];
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hi   = r_hi;
    assign o_rsp.lo   = r_lo;
endmodule
`default_nettype wire

// ===== rtl/core/risc_instruction_execute_unit.sv =====
// Top level: MIPS I integer execute unit, multicycle sequencer around shared units.
// ALU, branch and jump instructions go from execute straight to the result; loads and stores
// add a memory read and write step, and with a DMEM_WORDS that is not a power of two first
// find the word index by reciprocal multiply in the bit-serial multiply/divide unit, which
// MULT/DIV also use. One instruction at a time; ready again once the result register loads.
// Reset: synchronous; data memory is zero-filled before first accept.
`default_nettype none
module risc_instruction_execute_unit #(
    parameter int unsigned DMEM_WORDS = rie_pkg::DMEM_WORDS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rie_chan_if.sink    i_instr,
    rie_chan_if.source  o_result
);
    import rie_pkg::*;

    localparam int unsigned AW     = $clog2(DMEM_WORDS);
    localparam bit          IS_POW2 = (DMEM_WORDS & (DMEM_WORDS - 1)) == 0;
    localparam logic [AW-1:0] CLR_LAST = AW'(DMEM_WORDS - 1);
    localparam int unsigned IDX_SHIFT = 30 + AW;
    localparam logic [63:0] IDX_RECIP_W = (64'd1 << IDX_SHIFT) / 64'(DMEM_WORDS);
    localparam logic [31:0] IDX_RECIP = IDX_RECIP_W[31:0];
    localparam logic [AW:0] IDX_D = (AW+1)'(DMEM_WORDS);

    t_state      r_state;
    t_state      n_state;
    logic [31:0] r_ins;
    logic [31:0] r_pc;
    logic [31:0] r_pc4;
    logic [31:0] r_a;
    logic [31:0] r_hi;
    logic [31:0] r_lo;
    logic        r_halt;
    logic [31:0] r_npc;
    logic        r_we;
    logic [4:0]  r_widx;
    logic [31:0] r_wval;
    logic        r_mwe;
    logic [31:0] r_maddr;
    logic [31:0] r_mdata;
    logic [3:0]  r_mlanes;
    logic [AW-1:0] r_idx;
    logic [AW:0] r_rem;
    logic [AW-1:0] r_clr;
    logic [31:0] r_rf_vld;
    logic        r_rf_ok;
    logic        r_ovalid;
    t_result     r_out;

    logic [5:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [5:0]  fn;
    logic [31:0] imm_s;
    logic [31:0] imm_u;
    logic [31:0] b;
    logic [31:0] ea;
    logic [31:0] btarget;
    logic        is_sys;
    logic        is_load;
    logic        is_store;
    logic        accept;
    logic        leave;

    logic        ex_we;
    logic [4:0]  ex_widx;
    logic [31:0] ex_wval;
    logic [31:0] ex_npc;
    logic        ex_hi_we;
    logic        ex_lo_we;
    logic        ex_halt;
    logic        ex_md;
    t_md_op      ex_mdop;
    logic [31:0] ex_mda;
    logic [31:0] ex_mdb;
    logic        ex_mwe;
    logic        ex_mem;
    logic [31:0] ex_maddr;
    logic [31:0] ex_mdata;
    logic [3:0]  ex_mlanes;

    logic [4:0]  rf_raddr;
    logic [31:0] rf_q;
    logic [31:0] rf_val;
    logic        rf_we;
    logic        dm_we;
    logic [AW-1:0] dm_waddr;
    logic [31:0] dm_wdata;
    logic [31:0] dm_q;
    logic [31:0] lmask;
    logic [31:0] byte_w;
    logic [31:0] half_w;
    logic [31:0] ld_val;
    logic [63:0] idx_prod;
    logic [31:0] idx_rem;

    t_md_req     md_req;
    t_md_rsp     md_rsp;

    rie_ram #(.WIDTH(32), .DEPTH(32)) u_regfile (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_widx),
        .i_wdata (r_wval),
        .i_raddr (rf_raddr),
        .o_rdata (rf_q)
    );

    rie_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_raddr (r_idx),
        .o_rdata (dm_q)
    );

    rie_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    assign op      = r_ins[31:26];
    assign rs      = r_ins[25:21];
    assign rt      = r_ins[20:16];
    assign rd      = r_ins[15:11];
    assign sh      = r_ins[10:6];
    assign fn      = r_ins[5:0];
    assign imm_s   = {{16{r_ins[15]}}, r_ins[15:0]};
    assign imm_u   = {16'd0, r_ins[15:0]};
    assign rf_val  = r_rf_ok ? rf_q : 32'd0;
    assign b       = rf_val;
    assign ea      = r_a + imm_s;
    assign btarget = r_pc4 + {imm_s[29:0], 2'b00};
    assign is_sys  = (op == OP_SPECIAL) && (fn == FN_SYSCALL);
    assign is_load = (op == OP_LB) || (op == OP_LH) || (op == OP_LW) ||
                     (op == OP_LBU) || (op == OP_LHU);
    assign is_store = (op == OP_SB) || (op == OP_SH) || (op == OP_SW);

    // word index: reciprocal quotient is low by at most one, remainder below 2*DMEM_WORDS
    assign idx_prod = {md_rsp.hi, md_rsp.lo} >> IDX_SHIFT;
    assign idx_rem  = {2'b00, ea[31:2]} - ({2'b00, idx_prod[29:0]} * 32'(DMEM_WORDS));

    assign i_instr.ready  = (r_state == ST_IDLE);
    assign accept         = i_instr.valid && i_instr.ready;
    assign leave          = (r_state == ST_DONE) && (!r_ovalid || o_result.ready);
    assign rf_we          = leave && r_we;
    assign o_result.valid = r_ovalid;
    assign o_result.data  = r_out;

    // execute decode
    always_comb begin
        ex_we     = 1'b0;
        ex_widx   = rt;
        ex_wval   = 32'd0;
        ex_npc    = r_pc4;
        ex_hi_we  = 1'b0;
        ex_lo_we  = 1'b0;
        ex_halt   = 1'b0;
        ex_md     = 1'b0;
        ex_mdop   = MD_MULTU;
        ex_mda    = r_a;
        ex_mdb    = b;
        ex_mwe    = 1'b0;
        ex_mem    = 1'b0;
        ex_maddr  = 32'd0;
        ex_mdata  = 32'd0;
        ex_mlanes = 4'd0;
        if (op == OP_SPECIAL) begin
            ex_widx = rd;
            unique case (fn)
                FN_SLL:  begin ex_we = 1'b1; ex_wval = b << sh; end
                FN_SRL:  begin ex_we = 1'b1; ex_wval = b >> sh; end
                FN_SRA:  begin ex_we = 1'b1; ex_wval = 32'($signed(b) >>> sh); end
                FN_SLLV: begin ex_we = 1'b1; ex_wval = b << r_a[4:0]; end
                FN_SRLV: begin ex_we = 1'b1; ex_wval = b >> r_a[4:0]; end
                FN_SRAV: begin ex_we = 1'b1; ex_wval = 32'($signed(b) >>> r_a[4:0]); end
                FN_JR:   ex_npc = r_a;
                FN_JALR: begin ex_we = 1'b1; ex_wval = r_pc4; ex_npc = r_a; end
                FN_SYSCALL: ex_halt = (r_a == SYSCALL_HALT);
                FN_MFHI: begin ex_we = 1'b1; ex_wval = r_hi; end
                FN_MTHI: ex_hi_we = 1'b1;
                FN_MFLO: begin ex_we = 1'b1; ex_wval = r_lo; end
                FN_MTLO: ex_lo_we = 1'b1;
                FN_MULT: begin ex_md = 1'b1; ex_mdop = MD_MULT; end
                FN_MULTU: begin ex_md = 1'b1; ex_mdop = MD_MULTU; end
                FN_DIV:  begin ex_md = (b != 32'd0); ex_mdop = MD_DIV; end
                FN_DIVU: begin ex_md = (b != 32'd0); ex_mdop = MD_DIVU; end
                FN_ADD, FN_ADDU: begin ex_we = 1'b1; ex_wval = r_a + b; end
                FN_SUB, FN_SUBU: begin ex_we = 1'b1; ex_wval = r_a - b; end
                FN_AND:  begin ex_we = 1'b1; ex_wval = r_a & b; end
                FN_OR:   begin ex_we = 1'b1; ex_wval = r_a | b; end
                FN_XOR:  begin ex_we = 1'b1; ex_wval = r_a ^ b; end
                FN_NOR:  begin ex_we = 1'b1; ex_wval = ~(r_a | b); end
                FN_SLT:  begin
                    ex_we = 1'b1; ex_wval = {31'd0, $signed(r_a) < $signed(b)};
                end
                FN_SLTU: begin ex_we = 1'b1; ex_wval = {31'd0, r_a < b}; end
                default: ;
            endcase
        end else begin
            unique case (op)
                OP_REGIMM: begin
                    if ((rt == RT_BLTZ) || (rt == RT_BLTZAL)) begin
                        if (r_a[31]) ex_npc = btarget;
                    end else if ((rt == RT_BGEZ) || (rt == RT_BGEZAL)) begin
                        if (!r_a[31]) ex_npc = btarget;
                    end
                    if ((rt == RT_BLTZAL) || (rt == RT_BGEZAL)) begin
                        ex_we = 1'b1; ex_widx = REG_RA; ex_wval = r_pc4;
                    end
                end
                OP_J:   ex_npc = {r_pc4[31:28], r_ins[25:0], 2'b00};
                OP_JAL: begin
                    ex_we = 1'b1; ex_widx = REG_RA; ex_wval = r_pc4;
                    ex_npc = {r_pc4[31:28], r_ins[25:0], 2'b00};
                end
                OP_BEQ:  if (r_a == b) ex_npc = btarget;
                OP_BNE:  if (r_a != b) ex_npc = btarget;
                OP_BLEZ: if ((r_a == 32'd0) || r_a[31]) ex_npc = btarget;
                OP_BGTZ: if ((r_a != 32'd0) && !r_a[31]) ex_npc = btarget;
                OP_ADDI, OP_ADDIU: begin ex_we = 1'b1; ex_wval = r_a + imm_s; end
                OP_SLTI: begin
                    ex_we = 1'b1; ex_wval = {31'd0, $signed(r_a) < $signed(imm_s)};
                end
                OP_SLTIU: begin ex_we = 1'b1; ex_wval = {31'd0, r_a < imm_s}; end
                OP_ANDI: begin ex_we = 1'b1; ex_wval = r_a & imm_u; end
                OP_ORI:  begin ex_we = 1'b1; ex_wval = r_a | imm_u; end
                OP_XORI: begin ex_we = 1'b1; ex_wval = r_a ^ imm_u; end
                OP_LUI:  begin ex_we = 1'b1; ex_wval = {r_ins[15:0], 16'd0}; end
                OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
                    ex_we = 1'b1; ex_mem = 1'b1; ex_maddr = ea;
                end
                OP_SB: begin
                    ex_mwe = 1'b1; ex_mem = 1'b1; ex_maddr = ea;
                    ex_mlanes = 4'b0001 << ea[1:0];
                    ex_mdata  = {24'd0, b[7:0]} << {ea[1:0], 3'b000};
                end
                OP_SH: begin
                    ex_mwe = 1'b1; ex_mem = 1'b1; ex_maddr = ea;
                    ex_mlanes = 4'b0011 << {ea[1], 1'b0};
                    ex_mdata  = {16'd0, b[15:0]} << {ea[1], 4'b0000};
                end
                OP_SW: begin
                    ex_mwe = 1'b1; ex_mem = 1'b1; ex_maddr = ea;
                    ex_mlanes = 4'b1111; ex_mdata = b;
                end
                default: ;
            endcase
        end
        if (ex_mem && !IS_POW2) begin
            ex_md   = 1'b1;
            ex_mdop = MD_MULTU;
            ex_mda  = {2'b00, ea[31:2]};
            ex_mdb  = IDX_RECIP;
        end
        if (ex_widx == 5'd0) begin
            ex_we = 1'b0;
        end
        if (!ex_we) begin
            ex_widx = 5'd0;
            ex_wval = 32'd0;
        end
    end

    assign md_req.start = (r_state == ST_EXEC) && ex_md;
    assign md_req.op    = ex_mdop;
    assign md_req.a     = ex_mda;
    assign md_req.b     = ex_mdb;

    // load lane extraction, store merge, register read address and data memory write select
    always_comb begin
        lmask  = {{8{r_mlanes[3]}}, {8{r_mlanes[2]}}, {8{r_mlanes[1]}}, {8{r_mlanes[0]}}};
        byte_w = dm_q >> {r_maddr[1:0], 3'b000};
        half_w = dm_q >> {r_maddr[1], 4'b0000};
        unique case (op)
            OP_LB:   ld_val = {{24{byte_w[7]}}, byte_w[7:0]};
            OP_LBU:  ld_val = {24'd0, byte_w[7:0]};
            OP_LH:   ld_val = {{16{half_w[15]}}, half_w[15:0]};
            OP_LHU:  ld_val = {16'd0, half_w[15:0]};
            default: ld_val = dm_q;
        endcase
        rf_raddr = ((r_state == ST_RDA) && is_sys) ? REG_V0 :
                   (r_state == ST_RDA) ? rs : rt;
        dm_we    = (r_state == ST_CLEAR) || ((r_state == ST_MEMWR) && r_mwe);
        dm_waddr = (r_state == ST_CLEAR) ? r_clr : r_idx;
        dm_wdata = (r_state == ST_CLEAR) ? 32'd0 : ((dm_q & ~lmask) | (r_mdata & lmask));
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr == CLR_LAST) n_state = ST_IDLE;
            ST_IDLE:   if (accept) n_state = r_halt ? ST_DONE : ST_RDA;
            ST_RDA:    n_state = ST_RDB;
            ST_RDB:    n_state = ST_EXEC;
            ST_EXEC: begin
                if (ex_md) begin
                    n_state = ST_MDWAIT;
                end else if (ex_mem) begin
                    n_state = ST_MEMRD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_MDWAIT: begin
                if (md_rsp.done) begin
                    n_state = (is_load || is_store) ? ST_IDXFIX : ST_DONE;
                end
            end
            ST_IDXFIX: n_state = ST_MEMRD;
            ST_MEMRD:  n_state = ST_MEMWR;
            ST_MEMWR:  n_state = ST_DONE;
            ST_DONE:   if (leave) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_pc     <= PC_RESET;
            r_hi     <= 32'd0;
            r_lo     <= 32'd0;
            r_halt   <= 1'b0;
            r_rf_vld <= 32'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if ((r_state == ST_EXEC) && !r_halt) begin
                if (ex_hi_we) r_hi <= r_a;
                if (ex_lo_we) r_lo <= r_a;
                if (ex_halt)  r_halt <= 1'b1;
            end
            if ((r_state == ST_MDWAIT) && md_rsp.done && !(is_load || is_store)) begin
                r_hi <= md_rsp.hi;
                r_lo <= md_rsp.lo;
            end
            if (rf_we) begin
                r_rf_vld[r_widx] <= 1'b1;
            end
            if (leave) begin
                r_pc     <= r_npc;
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rf_ok <= r_rf_vld[rf_raddr];
        if (accept) begin
            r_ins    <= i_instr.data.instr_word;
            r_npc    <= r_pc;
            r_we     <= 1'b0;
            r_widx   <= 5'd0;
            r_wval   <= 32'd0;
            r_mwe    <= 1'b0;
            r_maddr  <= 32'd0;
            r_mdata  <= 32'd0;
            r_mlanes <= 4'd0;
        end
        if (r_state == ST_RDA) begin
            r_pc4 <= r_pc + 32'd4;
        end
        if (r_state == ST_RDB) begin
            r_a <= rf_val;
        end
        if (r_state == ST_EXEC) begin
            r_npc    <= ex_npc;
            r_we     <= ex_we;
            r_widx   <= ex_widx;
            r_wval   <= ex_wval;
            r_mwe    <= ex_mwe;
            r_maddr  <= ex_maddr;
            r_mdata  <= ex_mdata;
            r_mlanes <= ex_mlanes;
            r_idx    <= ea[AW+1:2];
        end
        if ((r_state == ST_MDWAIT) && md_rsp.done) begin
            r_rem <= idx_rem[AW:0];
        end
        if (r_state == ST_IDXFIX) begin
            r_idx <= (r_rem >= IDX_D) ? AW'(r_rem - IDX_D) : r_rem[AW-1:0];
        end
        if ((r_state == ST_MEMWR) && r_we) begin
            r_wval <= ld_val;
        end
        if (leave) begin
            r_out.next_pc   <= r_npc;
            r_out.reg_we    <= r_we;
            r_out.reg_idx   <= r_widx;
            r_out.reg_val   <= r_wval;
            r_out.hi_val    <= r_hi;
            r_out.lo_val    <= r_lo;
            r_out.mem_we    <= r_mwe;
            r_out.mem_addr  <= r_maddr;
            r_out.mem_wdata <= r_mdata;
            r_out.mem_lanes <= r_mlanes;
            r_out.halted    <= r_halt;
        end
    end

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared");

    a_no_r0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_we |-> (r_widx != 5'd0))
        else $error("write to register zero");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_instr.ready)
        else $error("accept during memory clear");

    a_md_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_req.start |=> (r_state == ST_MDWAIT) && !md_req.start)
        else $error("multiply/divide restarted");
endmodule
`default_nettype wire

// ===== verif/rie_exec_checker.sv =====
// Checker: watches both channels, predicts execute results and compares them.
module rie_exec_checker
    import rie_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rie_chan_if        i_instr,
    rie_chan_if        o_result,
    output int         o_fail_cnt,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] gpr [32];
    logic [31:0] hi_q, lo_q, pc_q;
    logic [31:0] dmem [DMEM_WORDS_DEF];
    logic        halt_q;
    t_result     expected_q [$];

    function automatic logic [31:0] sext(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic t_result execute(input logic [31:0] ins);
        t_result     r;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sh;
        logic [31:0] a, b, imm, uimm, npc, bt, ea, w, mask, q, rm;
        logic [63:0] p;
        logic        we, neg;
        logic [4:0]  widx;
        logic [31:0] wval;
        int unsigned wi;
        r = '0;
        op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
        sh = ins[10:6]; fn = ins[5:0];
        a = gpr[rs]; b = gpr[rt];
        imm = sext(ins[15:0]); uimm = {16'h0, ins[15:0]};
        npc = pc_q + 4; bt = npc + (imm << 2); ea = a + imm;
        we = 0; widx = 0; wval = 0;
        wi = (ea >> 2) % DMEM_WORDS_DEF;
        if (halt_q) begin
            npc = pc_q;
        end else if (op == OP_SPECIAL) begin
            widx = rd;
            case (fn)
                FN_SLL:  begin we = 1; wval = b << sh; end
                FN_SRL:  begin we = 1; wval = b >> sh; end
                FN_SRA:  begin we = 1; wval = $signed(b) >>> sh; end
                FN_SLLV: begin we = 1; wval = b << a[4:0]; end
                FN_SRLV: begin we = 1; wval = b >> a[4:0]; end
                FN_SRAV: begin we = 1; wval = $signed(b) >>> a[4:0]; end
                FN_JR:   npc = a;
                FN_JALR: begin we = 1; wval = pc_q + 4; npc = a; end
                FN_SYSCALL: if (gpr[REG_V0] == SYSCALL_HALT) halt_q = 1;
                FN_MFHI: begin we = 1; wval = hi_q; end
                FN_MTHI: hi_q = a;
                FN_MFLO: begin we = 1; wval = lo_q; end
                FN_MTLO: lo_q = a;
                FN_MULT: begin
                    p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                    {hi_q, lo_q} = p;
                end
                FN_MULTU: begin p = {32'h0, a} * {32'h0, b}; {hi_q, lo_q} = p; end
                FN_DIV: if (b != 0) begin
                    q = (a[31] ? -a : a) / (b[31] ? -b : b);
                    rm = (a[31] ? -a : a) % (b[31] ? -b : b);
                    lo_q = (a[31] != b[31]) ? -q : q;
                    hi_q = a[31] ? -rm : rm;
                end
                FN_DIVU: if (b != 0) begin lo_q = a / b; hi_q = a % b; end
                FN_ADD, FN_ADDU: begin we = 1; wval = a + b; end
                FN_SUB, FN_SUBU: begin we = 1; wval = a - b; end
                FN_AND:  begin we = 1; wval = a & b; end
                FN_OR:   begin we = 1; wval = a | b; end
                FN_XOR:  begin we = 1; wval = a ^ b; end
                FN_NOR:  begin we = 1; wval = ~(a | b); end
                FN_SLT:  begin we = 1; wval = ($signed(a) < $signed(b)) ? 1 : 0; end
                FN_SLTU: begin we = 1; wval = (a < b) ? 1 : 0; end
                default: ;
            endcase
        end else begin
            widx = rt;
            case (op)
                OP_REGIMM: begin
                    neg = a[31];
                    if ((rt == RT_BLTZ || rt == RT_BLTZAL) && neg) npc = bt;
                    if ((rt == RT_BGEZ || rt == RT_BGEZAL) && !neg) npc = bt;
                    if (rt == RT_BLTZAL || rt == RT_BGEZAL) begin
                        we = 1; widx = REG_RA; wval = pc_q + 4;
                    end
                end
                OP_J:   npc = {npc[31:28], ins[25:0], 2'b00};
                OP_JAL: begin
                    we = 1; widx = REG_RA; wval = pc_q + 4;
                    npc = {npc[31:28], ins[25:0], 2'b00};
                end
                OP_BEQ:  if (a == b) npc = bt;
                OP_BNE:  if (a != b) npc = bt;
                OP_BLEZ: if (a == 0 || a[31]) npc = bt;
                OP_BGTZ: if (a != 0 && !a[31]) npc = bt;
                OP_ADDI, OP_ADDIU: begin we = 1; wval = a + imm; end
                OP_SLTI:  begin we = 1; wval = ($signed(a) < $signed(imm)) ? 1 : 0; end
                OP_SLTIU: begin we = 1; wval = (a < imm) ? 1 : 0; end
                OP_ANDI:  begin we = 1; wval = a & uimm; end
                OP_ORI:   begin we = 1; wval = a | uimm; end
                OP_XORI:  begin we = 1; wval = a ^ uimm; end
                OP_LUI:   begin we = 1; wval = uimm << 16; end
                OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
                    w = dmem[wi]; r.mem_addr = ea; we = 1;
                    case (op)
                        OP_LB:  wval = {{24{w[ea[1:0]*8+7]}}, w[ea[1:0]*8 +: 8]};
                        OP_LBU: wval = {24'h0, w[ea[1:0]*8 +: 8]};
                        OP_LH:  wval = sext(w[ea[1]*16 +: 16]);
                        OP_LHU: wval = {16'h0, w[ea[1]*16 +: 16]};
                        default: wval = w;
                    endcase
                end
                OP_SB, OP_SH, OP_SW: begin
                    r.mem_addr = ea; r.mem_we = 1;
                    if (op == OP_SB) begin
                        r.mem_lanes = 4'b0001 << ea[1:0];
                        r.mem_wdata = {24'h0, b[7:0]} << (ea[1:0] * 8);
                        mask = 32'hFF << (ea[1:0] * 8);
                    end else if (op == OP_SH) begin
                        r.mem_lanes = 4'b0011 << {ea[1], 1'b0};
                        r.mem_wdata = {16'h0, b[15:0]} << (ea[1] * 16);
                        mask = 32'hFFFF << (ea[1] * 16);
                    end else begin
                        r.mem_lanes = 4'hF; r.mem_wdata = b; mask = '1;
                    end
                    dmem[wi] = (dmem[wi] & ~mask) | (r.mem_wdata & mask);
                end
                default: ;
            endcase
        end
        if (we && widx != 0) begin
            gpr[widx] = wval;
            r.reg_we = 1; r.reg_idx = widx; r.reg_val = wval;
        end
        pc_q = npc;
        r.next_pc = npc; r.hi_val = hi_q; r.lo_val = lo_q; r.halted = halt_q;
        return r;
    endfunction

    task automatic cmp(input string nm, input logic [31:0] e, input logic [31:0] g);
        if (e !== g) begin
            $error("%s: expected %h, got %h", nm, e, g);
            o_fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result e, g;
        if (!i_rst_n) begin
            foreach (gpr[k]) gpr[k] = '0;
            foreach (dmem[k]) dmem[k] = '0;
            hi_q = 0; lo_q = 0; pc_q = PC_RESET; halt_q = 0;
            expected_q.delete();
        end else begin
            if (i_instr.valid && i_instr.ready)
                expected_q.push_back(execute(i_instr.data.instr_word));
            if (o_result.valid && o_result.ready) begin
                g = o_result.data;
                if (expected_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    o_fail_cnt++;
                end else begin
                    e = expected_q.pop_front();
                    cmp("next_pc", e.next_pc, g.next_pc);
                    cmp("reg_we", e.reg_we, g.reg_we);
                    cmp("reg_idx", e.reg_idx, g.reg_idx);
                    cmp("reg_val", e.reg_val, g.reg_val);
                    cmp("hi_val", e.hi_val, g.hi_val);
                    cmp("lo_val", e.lo_val, g.lo_val);
                    cmp("mem_we", e.mem_we, g.mem_we);
                    cmp("mem_addr", e.mem_addr, g.mem_addr);
                    cmp("mem_wdata", e.mem_wdata, g.mem_wdata);
                    cmp("mem_lanes", e.mem_lanes, g.mem_lanes);
                    cmp("halted", e.halted, g.halted);
                end
            end
        end
        o_pending <= expected_q.size();
    end

    initial o_fail_cnt = 0;
endmodule

// ===== verif/tb.sv =====
// Testbench top: clock, reset, instruction stimulus, result back-pressure and the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rie_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   fail_cnt, pending, cyc = 0;
    int   src_idle = 0, snk_idle = 0;
    logic [31:0] prog [$];

    rie_chan_if #(.T(t_instr))  instr_if ();
    rie_chan_if #(.T(t_result)) result_if ();

    risc_instruction_execute_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_instr(instr_if.sink), .o_result(result_if.source)
    );

    rie_exec_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_instr(instr_if), .o_result(result_if),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > 2_000_000) begin
            $display("status: fail");
            $finish;
        end
    end

    initial result_if.ready = 0;
    always @(negedge i_clk)
        result_if.ready <= ($urandom_range(99) >= snk_idle);

    function automatic logic [31:0] rtype(input logic [4:0] rs, rt, rd, sh, input logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs, rt,
                                          input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] rand_instr();
        logic [5:0] ops [24] = '{OP_SPECIAL, OP_SPECIAL, OP_SPECIAL, OP_REGIMM, OP_J, OP_JAL,
            OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI,
            OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LH, OP_LW, OP_SB, OP_SH, OP_SW};
        logic [5:0] fns [26] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
            FN_JALR, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU,
            FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
        logic [31:0] w;
        logic [5:0]  op;
        w = $urandom();
        case ($urandom_range(19))
            0: return w;
            1: return {OP_LBU + 6'($urandom_range(1)), w[25:0]};
            default: begin
                op = ops[$urandom_range(23)];
                if (op == OP_SPECIAL) begin
                    w[5:0] = fns[$urandom_range(25)];
                    if (w[5:0] == FN_JR || w[5:0] == FN_JALR) w[25:21] = 5'd0;
                end
                if (op == OP_REGIMM) w[20:16] = {w[20], 3'b000, w[16]};
                if (op inside {OP_LB, OP_LH, OP_LW, OP_SB, OP_SH, OP_SW} && $urandom_range(1))
                    w[25:21] = 5'd0;
                if (w[4:0] == 5'd2 && $urandom_range(3)) w[4:0] = 5'd3;
                return {op, w[25:0]};
            end
        endcase
    endfunction

    task automatic send(input logic [31:0] w);
        instr_if.valid <= 1;
        instr_if.data  <= w;
        do @(posedge i_clk); while (!instr_if.ready);
        @(negedge i_clk);
        if ($urandom_range(99) < src_idle) begin
            instr_if.valid <= 0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
    endtask

    initial begin
        instr_if.valid = 0;
        instr_if.data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        prog = '{
            itype(OP_LUI, 0, 1, 16'h8000), itype(OP_ADDI, 0, 2, 16'hFFFF),
            itype(OP_ORI, 0, 3, 16'hFFFF), itype(OP_SLTIU, 1, 4, 16'h8000),
            itype(OP_XORI, 2, 5, 16'hFFFF), itype(OP_ANDI, 2, 6, 16'h00F0),
            rtype(1, 2, 7, 0, FN_DIV), rtype(1, 0, 7, 0, FN_DIVU),
            rtype(1, 2, 0, 0, FN_MULT), rtype(2, 2, 0, 0, FN_MULTU),
            rtype(0, 1, 8, 31, FN_SRA), rtype(2, 1, 9, 0, FN_SRLV),
            rtype(0, 0, 0, 0, FN_ADD), itype(OP_SW, 0, 2, 16'h0006),
            itype(OP_SB, 0, 1, 16'hFFFD), itype(OP_SH, 0, 3, 16'h0003),
            itype(OP_LB, 0, 10, 16'h0007), itype(OP_LHU, 0, 11, 16'h0006),
            itype(OP_LH, 0, 12, 16'hFFFE), {OP_REGIMM, 5'd1, RT_BLTZAL, 16'h0001},
            {OP_REGIMM, 5'd0, RT_BGEZAL, 16'hFFFF}, {OP_JAL, 26'h3FFFFFF},
            rtype(0, 0, 0, 0, FN_SYSCALL), 32'hFC00_0000
        };
        foreach (prog[k]) send(prog[k]);
        for (int k = 0; k < 1450; k++) begin
            if (k == 480) begin src_idle = 75; snk_idle = 11; end
            if (k == 960) begin src_idle = 0; snk_idle = 0; end
            send(rand_instr());
        end
        send(itype(OP_ADDIU, 0, 2, 16'd10));
        send(rtype(0, 0, 0, 0, FN_SYSCALL));
        send(rand_instr());
        send(rand_instr());
        instr_if.valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        src_idle = 11;
        snk_idle = 75;
    end
endmodule
